// ===== rtl/linear_recurrence_matrix_power_defines.svh =====
// assertion macros for the recurrence block
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_DEFINES_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_DEFINES_SVH

`ifndef SYNTH
`define LRMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrmp check failed");
`define LRMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrmp check failed");
`else
`define LRMP_ASSERT_IMP(lbl, ante, cons)
`define LRMP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/lrmp_pkg.sv =====
`default_nettype none

package lrmp_pkg;

    localparam int OP_W           = 16;
    localparam int VALUE_W        = 14;
    localparam int INDEX_W        = 32;
    localparam int DEF_MODULUS    = 10007;
    localparam int DEF_INDEX_BITS = 32;

    // matrix store address: bank, row, column
    localparam int BANK_W    = 2;
    localparam int DIM_W     = 2;
    localparam int ADDR_W    = BANK_W + 2 * DIM_W;
    localparam int MEM_DEPTH = 3 * (1 << (2 * DIM_W));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_ISSUE,
        ST_RED_DRAIN,
        ST_INIT,
        ST_STEP,
        ST_MUL_ISSUE,
        ST_MUL_DRAIN,
        ST_SQR_ISSUE,
        ST_SQR_DRAIN,
        ST_FIN_ISSUE,
        ST_FIN_DRAIN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        DST_MEM,
        DST_A,
        DST_B,
        DST_C,
        DST_RES
    } dst_t;

    typedef struct packed {
        logic              first;
        logic              last;
        dst_t              dst;
        logic [ADDR_W-1:0] waddr;
    } tag_t;

endpackage

`default_nettype wire

// ===== rtl/linear_recurrence_matrix_power.sv =====
`default_nettype none
`include "linear_recurrence_matrix_power_defines.svh"

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------
// in       | input     | in_valid / in_ready  | term_index, coef_a, coef_b, coef_c
// out      | output    | out_valid / out_ready| term_value
//
// one item at a time; an index of 2 or less skips setup and products and gives a result of 0
// otherwise coefficient reduction and matrix setup, then per bit of n-2 one or two 4x4
// products (64 multiplies each, then a pipe drain), all through the single
// multiply-reduce pipe, which takes one multiply per cycle
// a finished result waits in the output register; a new item is taken meanwhile
// asynchronous reset clears the sequencer, pipe valids and the output valid

module linear_recurrence_matrix_power
    import lrmp_pkg::*;
#(
    parameter int MODULUS    = DEF_MODULUS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [INDEX_W-1:0] term_index,
    input  logic [OP_W-1:0]    coef_a,
    input  logic [OP_W-1:0]    coef_b,
    input  logic [OP_W-1:0]    coef_c,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] term_value
);

    localparam int RES_W = (MODULUS > 2) ? $clog2(MODULUS) : 1;
    localparam int PW    = (2 * RES_W > OP_W) ? 2 * RES_W : OP_W;
    localparam int EXP_W = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;

    localparam logic [63:0]      BAR_FULL = (64'd1 << PW) / 64'(MODULUS);
    localparam logic [PW-1:0]    BAR_M    = BAR_FULL[PW-1:0];
    localparam logic [PW-1:0]    MOD_PW   = PW'(MODULUS);
    localparam logic [RES_W:0]   MOD_R1   = (RES_W + 1)'(MODULUS);
    localparam logic [RES_W-1:0] ONE_RES  = RES_W'(1);

    state_t state_reg, state_next;

    logic [EXP_W-1:0]  p_reg, p_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [BANK_W-1:0] acc_bank_reg, acc_bank_next;
    logic [BANK_W-1:0] base_bank_reg, base_bank_next;
    logic [BANK_W-1:0] free_bank_reg, free_bank_next;
    logic              out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;

    logic [OP_W-1:0]  raw_a_reg, raw_b_reg, raw_c_reg;
    logic [RES_W-1:0] red_a_reg, red_b_reg, red_c_reg;
    logic [RES_W-1:0] res_reg;
    logic [RES_W-1:0] sum_reg;

    logic [RES_W-1:0] mem [0:MEM_DEPTH-1];

    // pipe stages
    logic             s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    tag_t             s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic             s1_xmem_reg, s1_ymem_reg;
    logic [OP_W-1:0]  s1_xi_reg, s1_yi_reg;
    logic [RES_W-1:0] rd_a_reg, rd_b_reg;
    logic [PW-1:0]    s2_prod_reg, s3_prod_reg, s3_q_reg;
    logic [RES_W:0]   s4_t_reg;

    // sequencer outputs
    logic              issue_v;
    tag_t              issue_tag;
    logic              issue_xmem, issue_ymem;
    logic [OP_W-1:0]   issue_xi, issue_yi;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic              init_we;
    logic [ADDR_W-1:0] init_addr;
    logic [RES_W-1:0]  init_data;

    logic [EXP_W-1:0]  n_idx;
    logic              small_idx;
    logic              in_xfer;
    logic              pipe_busy;
    logic              out_load;

    logic [OP_W-1:0]     x_op, y_op;
    logic [2*OP_W-1:0]   prod_full;
    logic [2*PW-1:0]     q_full;
    logic [2*PW-1:0]     qm_full;
    logic [PW-1:0]       diff;
    logic [RES_W:0]      r_wide;
    logic [RES_W-1:0]    r5;
    logic [RES_W:0]      sum_wide;
    logic [RES_W:0]      sum_red;
    logic [RES_W-1:0]    sum_val;
    logic                pipe_we;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [RES_W-1:0]    mem_wdata;
    logic [RES_W+VALUE_W-1:0] res_ext;

    assign n_idx     = term_index[EXP_W-1:0];
    assign small_idx = (n_idx <= EXP_W'(2));
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign pipe_busy = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg;
    assign out_valid = out_valid_reg;
    assign term_value = out_value_reg;
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign res_ext   = {{VALUE_W{1'b0}}, res_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = small_idx ? ST_EMIT : ST_RED_ISSUE;
                end
            end
            ST_RED_ISSUE:
            begin
                if (cnt_reg == 6'd2)
                begin
                    state_next = ST_RED_DRAIN;
                end
            end
            ST_RED_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (cnt_reg == 6'd31)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (p_reg == '0)
                begin
                    state_next = ST_FIN_ISSUE;
                end
                else if (p_reg[0])
                begin
                    state_next = ST_MUL_ISSUE;
                end
                else
                begin
                    state_next = ST_SQR_ISSUE;
                end
            end
            ST_MUL_ISSUE:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_MUL_DRAIN;
                end
            end
            ST_MUL_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ((p_reg >> 1) == '0) ? ST_FIN_ISSUE : ST_SQR_ISSUE;
                end
            end
            ST_SQR_ISSUE:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_SQR_DRAIN;
                end
            end
            ST_SQR_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_FIN_ISSUE:
            begin
                state_next = ST_FIN_DRAIN;
            end
            ST_FIN_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        issue_v    = 1'b0;
        issue_tag  = '{first: 1'b0, last: 1'b0, dst: DST_MEM, waddr: '0};
        issue_xmem = 1'b0;
        issue_ymem = 1'b0;
        issue_xi   = '0;
        issue_yi   = '0;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        init_we    = 1'b0;
        init_addr  = '0;
        init_data  = '0;
        case (state_reg)
            ST_RED_ISSUE:
            begin
                issue_v         = 1'b1;
                issue_yi        = OP_W'(1);
                issue_tag.first = 1'b1;
                issue_tag.last  = 1'b1;
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        issue_xi      = raw_a_reg;
                        issue_tag.dst = DST_A;
                    end
                    2'd1:
                    begin
                        issue_xi      = raw_b_reg;
                        issue_tag.dst = DST_B;
                    end
                    default:
                    begin
                        issue_xi      = raw_c_reg;
                        issue_tag.dst = DST_C;
                    end
                endcase
            end
            ST_INIT:
            begin
                init_we   = 1'b1;
                init_addr = {(cnt_reg[4] ? base_bank_reg : acc_bank_reg), cnt_reg[3:0]};
                if (!cnt_reg[4])
                begin
                    init_data = (cnt_reg[3:2] == cnt_reg[1:0]) ? ONE_RES : '0;
                end
                else
                begin
                    case (cnt_reg[3:0])
                        4'b0000: init_data = red_a_reg;
                        4'b0010: init_data = red_b_reg;
                        4'b0011: init_data = ONE_RES;
                        4'b0100: init_data = ONE_RES;
                        4'b1001: init_data = ONE_RES;
                        4'b1111: init_data = ONE_RES;
                        default: init_data = '0;
                    endcase
                end
            end
            ST_MUL_ISSUE, ST_SQR_ISSUE:
            begin
                issue_v         = 1'b1;
                issue_xmem      = 1'b1;
                issue_ymem      = 1'b1;
                rd_addr_a       = {((state_reg == ST_MUL_ISSUE) ? acc_bank_reg : base_bank_reg),
                                   cnt_reg[5:4], cnt_reg[1:0]};
                rd_addr_b       = {base_bank_reg, cnt_reg[1:0], cnt_reg[3:2]};
                issue_tag.first = (cnt_reg[1:0] == 2'd0);
                issue_tag.last  = (cnt_reg[1:0] == 2'd3);
                issue_tag.dst   = DST_MEM;
                issue_tag.waddr = {free_bank_reg, cnt_reg[5:4], cnt_reg[3:2]};
            end
            ST_FIN_ISSUE:
            begin
                issue_v         = 1'b1;
                issue_xmem      = 1'b1;
                rd_addr_a       = {acc_bank_reg, 2'd0, 2'd3};
                issue_yi        = OP_W'(red_c_reg);
                issue_tag.first = 1'b1;
                issue_tag.last  = 1'b1;
                issue_tag.dst   = DST_RES;
            end
            default:
            begin
            end
        endcase
    end

    // counters, exponent, bank roles, output valid
    always_comb
    begin
        cnt_next       = '0;
        p_next         = p_reg;
        acc_bank_next  = acc_bank_reg;
        base_bank_next = base_bank_reg;
        free_bank_next = free_bank_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p_next         = n_idx - EXP_W'(2);
                    acc_bank_next  = BANK_W'(0);
                    base_bank_next = BANK_W'(1);
                    free_bank_next = BANK_W'(2);
                end
            end
            ST_RED_ISSUE, ST_INIT, ST_MUL_ISSUE, ST_SQR_ISSUE:
            begin
                cnt_next = cnt_reg + 6'd1;
            end
            ST_MUL_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    acc_bank_next  = free_bank_reg;
                    free_bank_next = acc_bank_reg;
                end
            end
            ST_SQR_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    base_bank_next = free_bank_reg;
                    free_bank_next = base_bank_reg;
                    p_next         = p_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p_reg         <= '0;
            cnt_reg       <= '0;
            acc_bank_reg  <= BANK_W'(0);
            base_bank_reg <= BANK_W'(1);
            free_bank_reg <= BANK_W'(2);
            out_valid_reg <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            cnt_reg       <= cnt_next;
            acc_bank_reg  <= acc_bank_next;
            base_bank_reg <= base_bank_next;
            free_bank_reg <= free_bank_next;
            out_valid_reg <= out_valid_next;
            s1_v_reg      <= issue_v;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
        end
    end

    // multiply-reduce pipe: product, reciprocal estimate, remainder, fold and sum
    assign x_op      = s1_xmem_reg ? OP_W'(rd_a_reg) : s1_xi_reg;
    assign y_op      = s1_ymem_reg ? OP_W'(rd_b_reg) : s1_yi_reg;
    assign prod_full = x_op * y_op;
    assign q_full    = s2_prod_reg * BAR_M;
    assign qm_full   = s3_q_reg * MOD_PW;
    assign diff      = s3_prod_reg - qm_full[PW-1:0];

    assign r_wide   = (s4_t_reg >= MOD_R1) ? (s4_t_reg - MOD_R1) : s4_t_reg;
    assign r5       = r_wide[RES_W-1:0];
    assign sum_wide = s4_tag_reg.first ? {1'b0, r5} : ({1'b0, sum_reg} + {1'b0, r5});
    assign sum_red  = (sum_wide >= MOD_R1) ? (sum_wide - MOD_R1) : sum_wide;
    assign sum_val  = sum_red[RES_W-1:0];

    assign pipe_we   = s4_v_reg && s4_tag_reg.last && (s4_tag_reg.dst == DST_MEM);
    assign mem_we    = init_we || pipe_we;
    assign mem_waddr = init_we ? init_addr : s4_tag_reg.waddr;
    assign mem_wdata = init_we ? init_data : sum_val;

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= issue_tag;
        s1_xmem_reg <= issue_xmem;
        s1_ymem_reg <= issue_ymem;
        s1_xi_reg   <= issue_xi;
        s1_yi_reg   <= issue_yi;
        s2_tag_reg  <= s1_tag_reg;
        s2_prod_reg <= prod_full[PW-1:0];
        s3_tag_reg  <= s2_tag_reg;
        s3_prod_reg <= s2_prod_reg;
        s3_q_reg    <= q_full[2*PW-1:PW];
        s4_tag_reg  <= s3_tag_reg;
        s4_t_reg    <= diff[RES_W:0];
        if (s4_v_reg)
        begin
            sum_reg <= sum_val;
        end
        if (in_xfer)
        begin
            raw_a_reg <= coef_a;
            raw_b_reg <= coef_b;
            raw_c_reg <= coef_c;
        end
        if (in_xfer && small_idx)
        begin
            res_reg <= '0;
        end
        else if (s4_v_reg && s4_tag_reg.last && (s4_tag_reg.dst == DST_RES))
        begin
            res_reg <= sum_val;
        end
        if (s4_v_reg && s4_tag_reg.last)
        begin
            case (s4_tag_reg.dst)
                DST_A:   red_a_reg <= sum_val;
                DST_B:   red_b_reg <= sum_val;
                DST_C:   red_c_reg <= sum_val;
                default:
                begin
                end
            endcase
        end
        if (out_load)
        begin
            out_value_reg <= res_ext[VALUE_W-1:0];
        end
    end

    // checks
    `LRMP_ASSERT_IMP(a_store_in_range, mem_we, mem_wdata < RES_W'(MODULUS))
    `LRMP_ASSERT_IMP(a_banks_apart, 1'b1, (acc_bank_reg != base_bank_reg) && (acc_bank_reg != free_bank_reg) && (base_bank_reg != free_bank_reg))
    `LRMP_ASSERT_IMP(a_pipe_drained, (state_reg == ST_INIT) || (state_reg == ST_STEP), !pipe_busy)
    `LRMP_ASSERT_NEXT(a_out_loaded, out_load, out_valid && (term_value == $past(res_ext[VALUE_W-1:0])))

endmodule

`default_nettype wire
